@@ sv/ccm_pkg.sv @@
// Shared types and codes for the clique membership checker.
package ccm_pkg;

  localparam logic [1:0] ACT_EDGE    = 2'd0;
  localparam logic [1:0] ACT_MEMBER  = 2'd1;
  localparam logic [1:0] ACT_VERDICT = 2'd2;

  localparam logic [1:0] CMD_EDGE    = 2'd0;
  localparam logic [1:0] CMD_MEMBER  = 2'd1;
  localparam logic [1:0] CMD_VERDICT = 2'd2;
  localparam logic [1:0] CMD_FLAG    = 2'd3;

  localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [8:0] NODE_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] first_node;
    logic [7:0] second_node;
    logic       edge_value;
  } item_t;

  typedef struct packed {
    logic       all_adjacent;
    logic [8:0] member_count;
    logic       range_error;
  } result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] first_node;
    logic [7:0] second_node;
    logic       edge_value;
  } cmd_t;

endpackage

@@ sv/ccm_fifo.sv @@
// Small register queue used between the front and back parts and for results.
module ccm_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  input  logic  rd,
  output item_t rdata,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);

  item_t           slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

@@ sv/ccm_front.sv @@
// Front part: input handshake, node range checks, command classification, config register.
module ccm_front #(
  parameter int MAX_NODES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccm_pkg::item_t item,
  output logic          full,
  input  logic          cq_full,
  input  logic          clearing,
  output logic          cmd_push,
  output ccm_pkg::cmd_t cmd,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ccm_pkg::*;

  logic [8:0] node_count;
  logic       accept;
  logic       ok_first;
  logic       ok_second;
  logic       known_act;

  function automatic logic node_ok(logic [7:0] n, logic [8:0] cnt);
    node_ok = ({1'b0, n} < cnt) && (32'(n) < 32'(MAX_NODES));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_NODE_COUNT) begin
      node_count <= pwdata[8:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_NODE_COUNT) ? {23'b0, node_count} : '0;

  // no items while the matrix is being wiped after reset
  assign full   = cq_full || clearing;
  assign accept = push && !full;

  assign ok_first  = node_ok(item.first_node, node_count);
  assign ok_second = node_ok(item.second_node, node_count);

  always_comb begin
    cmd.first_node  = item.first_node;
    cmd.second_node = item.second_node;
    cmd.edge_value  = item.edge_value;
    cmd.kind        = CMD_FLAG;
    known_act       = 1'b1;
    case (item.action)
      ACT_EDGE: begin
        cmd.kind = (ok_first && ok_second) ? CMD_EDGE : CMD_FLAG;
      end
      ACT_MEMBER: begin
        cmd.kind = ok_first ? CMD_MEMBER : CMD_FLAG;
      end
      ACT_VERDICT: begin
        cmd.kind = CMD_VERDICT;
      end
      default: begin
        // unused action: drop the item
        known_act = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept && known_act;

endmodule

@@ sv/ccm_back.sv @@
// Back part: adjacency memory, seen mask memory and the command sequencer.
module ccm_back #(
  parameter int MAX_NODES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  ccm_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output ccm_pkg::result_t res,
  output logic             clearing
);
  import ccm_pkg::*;

  localparam int ROW_WORDS = (MAX_NODES + 63) / 64;
  localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int ROW_SPAN  = 1 << WW;
  localparam int NW        = $clog2(MAX_NODES);
  localparam int CW        = WW + 6;
  localparam int AW        = NW + WW;
  localparam int DEPTH     = MAX_NODES * ROW_SPAN;
  localparam logic [WW-1:0] LAST_WORD = WW'(ROW_WORDS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EDGE_W1 = 3'd2;
  localparam logic [2:0] ST_EDGE_W2 = 3'd3;
  localparam logic [2:0] ST_SCAN    = 3'd4;
  localparam logic [2:0] ST_WIPE    = 3'd5;

  logic [63:0] adj [DEPTH];
  logic [63:0] seen_mem [ROW_SPAN];
  logic [63:0] adj_q;
  logic [63:0] seen_q;

  logic          adj_we;
  logic [AW-1:0] adj_wa;
  logic [63:0]   adj_wd;
  logic [AW-1:0] adj_ra;
  logic          seen_we;
  logic [WW-1:0] seen_wa;
  logic [63:0]   seen_wd;
  logic [WW-1:0] seen_ra;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_addr_next;
  logic [WW-1:0] word_idx;
  logic [WW-1:0] word_idx_next;
  logic [WW-1:0] word_inc;
  cmd_t          cur;
  cmd_t          cur_next;
  logic          mism;
  logic          mism_next;
  logic          dup;
  logic          dup_next;
  logic          pairs_ok;
  logic          pairs_ok_next;
  logic [8:0]    members_seen;
  logic [8:0]    members_seen_next;
  logic          range_flag;
  logic          range_flag_next;

  logic [NW-1:0] h_row_a;
  logic [CW-1:0] h_col_b;
  logic [NW-1:0] c_row_a;
  logic [NW-1:0] c_row_b;
  logic [CW-1:0] c_col_a;
  logic [CW-1:0] c_col_b;
  logic [63:0]   own_bit;
  logic          hit;
  logic          mism_now;
  logic          dup_now;

  function automatic logic [63:0] put_bit(logic [63:0] w, logic [5:0] pos, logic v);
    logic [63:0] m;
    m = 64'(1) << pos;
    put_bit = v ? (w | m) : (w & ~m);
  endfunction

  assign h_row_a  = NW'(cmd.first_node);
  assign h_col_b  = CW'(cmd.second_node);
  assign c_row_a  = NW'(cur.first_node);
  assign c_row_b  = NW'(cur.second_node);
  assign c_col_a  = CW'(cur.first_node);
  assign c_col_b  = CW'(cur.second_node);
  assign word_inc = word_idx + 1'b1;
  assign own_bit  = 64'(1) << c_col_a[5:0];
  assign hit      = (word_idx == c_col_a[CW-1:6]);
  assign mism_now = mism || ((adj_q & seen_q) != seen_q);
  assign dup_now  = dup || (hit && (seen_q & own_bit) != '0);

  assign clearing = (state == ST_CLEAR);
  assign res.all_adjacent = pairs_ok;
  assign res.member_count = members_seen;
  assign res.range_error  = range_flag;

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    word_idx_next     = word_idx;
    cur_next          = cur;
    mism_next         = mism;
    dup_next          = dup;
    pairs_ok_next     = pairs_ok;
    members_seen_next = members_seen;
    range_flag_next   = range_flag;
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    adj_we            = 1'b0;
    adj_wa            = '0;
    adj_wd            = '0;
    adj_ra            = '0;
    seen_we           = 1'b0;
    seen_wa           = '0;
    seen_wd           = '0;
    seen_ra           = '0;
    case (state)
      ST_CLEAR: begin
        adj_we        = 1'b1;
        adj_wa        = clr_addr;
        seen_we       = 1'b1;
        seen_wa       = clr_addr[WW-1:0];
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_EDGE: begin
              cmd_pop    = 1'b1;
              cur_next   = cmd;
              adj_ra     = {h_row_a, h_col_b[CW-1:6]};
              state_next = ST_EDGE_W1;
            end
            CMD_MEMBER: begin
              cmd_pop       = 1'b1;
              cur_next      = cmd;
              adj_ra        = {h_row_a, {WW{1'b0}}};
              word_idx_next = '0;
              mism_next     = 1'b0;
              dup_next      = 1'b0;
              state_next    = ST_SCAN;
            end
            CMD_VERDICT: begin
              // hold the verdict until the result queue has room
              if (!res_full) begin
                cmd_pop           = 1'b1;
                res_push          = 1'b1;
                pairs_ok_next     = 1'b1;
                members_seen_next = '0;
                range_flag_next   = 1'b0;
                word_idx_next     = '0;
                state_next        = ST_WIPE;
              end
            end
            default: begin
              cmd_pop         = 1'b1;
              range_flag_next = 1'b1;
            end
          endcase
        end
      end
      ST_EDGE_W1: begin
        adj_we     = 1'b1;
        adj_wa     = {c_row_a, c_col_b[CW-1:6]};
        adj_wd     = put_bit(adj_q, c_col_b[5:0], cur.edge_value);
        // mirror word; same address only for a self edge, which writes the same bit
        adj_ra     = {c_row_b, c_col_a[CW-1:6]};
        state_next = ST_EDGE_W2;
      end
      ST_EDGE_W2: begin
        adj_we     = 1'b1;
        adj_wa     = {c_row_b, c_col_a[CW-1:6]};
        adj_wd     = put_bit(adj_q, c_col_a[5:0], cur.edge_value);
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        mism_next = mism_now;
        dup_next  = dup_now;
        if (hit) begin
          seen_we = 1'b1;
          seen_wa = word_idx;
          seen_wd = seen_q | own_bit;
        end
        if (word_idx == LAST_WORD) begin
          // a repeated member leaves the verdict and count alone
          if (mism_now && !dup_now) begin
            pairs_ok_next = 1'b0;
          end
          if (!dup_now && members_seen != '1) begin
            members_seen_next = members_seen + 1'b1;
          end
          state_next = ST_IDLE;
        end else begin
          word_idx_next = word_inc;
          adj_ra        = {c_row_a, word_inc};
          seen_ra       = word_inc;
        end
      end
      ST_WIPE: begin
        seen_we = 1'b1;
        seen_wa = word_idx;
        if (word_idx == LAST_WORD) begin
          state_next = ST_IDLE;
        end else begin
          word_idx_next = word_inc;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      pairs_ok     <= 1'b1;
      members_seen <= '0;
      range_flag   <= 1'b0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      pairs_ok     <= pairs_ok_next;
      members_seen <= members_seen_next;
      range_flag   <= range_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    word_idx <= word_idx_next;
    cur      <= cur_next;
    mism     <= mism_next;
    dup      <= dup_next;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj[adj_wa] <= adj_wd;
    end
    adj_q <= adj[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_q <= seen_mem[seen_ra];
  end

endmodule

@@ sv/clique_membership_checker.sv @@
// Top level of the clique membership checker: front, command queue, back, result queue.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------
//   input    | in        | push / full               | item   (action, nodes, value)
//   result   | out       | empty / pop               | result (verdict, count, error)
//   config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// An edge item does a read-modify-write of two adjacency words, a member item reads one
// adjacency and seen-mask word per cycle through the single read port, an end item wipes
// the seen mask, and an out-of-range item only sets the range flag.
// After reset the adjacency memory is cleared one word a cycle, MAX_NODES times the row
// span rounded up to a power of two; full stays high then. A two-entry queue lets the
// front take items while the back works; results wait in a second two-entry queue, and
// an end item stalls the back only while that queue is full.
module clique_membership_checker #(
  parameter int MAX_NODES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccm_pkg::item_t   item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output ccm_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ccm_pkg::*;

  cmd_t    cmd_in;
  cmd_t    cmd_head;
  logic    cmd_push;
  logic    cmd_pop;
  logic    cq_full;
  logic    cq_empty;
  logic    clearing;
  result_t res;
  logic    res_push;
  logic    res_full;

  ccm_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cq_full  (cq_full),
    .clearing (clearing),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ccm_fifo #(
    .item_t(cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .rd    (cmd_pop),
    .rdata (cmd_head),
    .full  (cq_full),
    .empty (cq_empty)
  );

  ccm_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cq_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  ccm_fifo #(
    .item_t(result_t),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .rd    (pop),
    .rdata (result),
    .full  (res_full),
    .empty (empty)
  );

endmodule

@@ sim/tb_clique_membership_checker.sv @@
// Self-checking testbench for the clique membership checker: random and directed items.
`timescale 1ns / 100ps

module tb_clique_membership_checker;
  import ccm_pkg::*;

  localparam int          MAX_NODES       = 256;
  localparam int          ITEM_TARGET     = 1150;
  localparam int          DRAIN_CYCLES    = 40;
  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  localparam logic [1:0]  NODE_COUNT_ADDR = 2'(4 * REG_NODE_COUNT);
  localparam logic [8:0]  COUNT_LIMIT     = 9'd511;

  class clique_tracker;
    bit [MAX_NODES-1:0] adjacency [MAX_NODES];
    bit [MAX_NODES-1:0] members_mask;
    bit                 all_pairs_ok;
    bit [8:0]           distinct_members;
    bit                 saw_bad_node;
    bit [8:0]           node_count;
    result_t            verdicts [$];
    int                 errors;

    function new();
      foreach (adjacency[i]) adjacency[i] = '0;
      node_count = NODE_COUNT_RESET;
      errors     = 0;
      start_set();
    endfunction

    function void start_set();
      members_mask     = '0;
      all_pairs_ok     = 1'b1;
      distinct_members = '0;
      saw_bad_node     = 1'b0;
    endfunction

    function bit node_ok(bit [7:0] n);
      return ({1'b0, n} < node_count) && (int'(n) < MAX_NODES);
    endfunction

    function void note_item(item_t it);
      bit [7:0] a;
      bit [7:0] b;
      result_t  r;
      a = it.first_node;
      b = it.second_node;
      case (it.action)
        ACT_EDGE: begin
          if (node_ok(a) && node_ok(b)) begin
            adjacency[a][b] = it.edge_value;
            adjacency[b][a] = it.edge_value;
          end else begin
            saw_bad_node = 1'b1;
          end
        end
        ACT_MEMBER: begin
          if (!node_ok(a)) begin
            saw_bad_node = 1'b1;
          end else if (!members_mask[a]) begin
            if ((adjacency[a] & members_mask) != members_mask) all_pairs_ok = 1'b0;
            members_mask[a] = 1'b1;
            if (distinct_members != COUNT_LIMIT) distinct_members++;
          end
        end
        ACT_VERDICT: begin
          r.all_adjacent = all_pairs_ok;
          r.member_count = distinct_members;
          r.range_error  = saw_bad_node;
          verdicts.push_back(r);
          start_set();
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (verdicts.size() == 0) begin
        report($sformatf("verdict %p arrived with none pending", got));
      end else begin
        want = verdicts.pop_front();
        if (got.all_adjacent !== want.all_adjacent)
          report($sformatf("all_adjacent %b, expected %b",
                           got.all_adjacent, want.all_adjacent));
        if (got.member_count !== want.member_count)
          report($sformatf("member_count %0d, expected %0d",
                           got.member_count, want.member_count));
        if (got.range_error !== want.range_error)
          report($sformatf("range_error %b, expected %b", got.range_error, want.range_error));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  item_t       item = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clique_tracker sb = new();
  bit            calm = 1'b0;
  int            items_sent = 0;
  int            pop_hold = 0;

  clique_membership_checker #(.MAX_NODES(MAX_NODES)) DUT (
    .clk(clk), .rst(rst),
    .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Track accepted items and verdicts on the pre-edge values.
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_item(item);
    if (!rst && pop && !empty) sb.check_result(result);
  end

  // Receiver: short random stalls plus an occasional long hold.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else begin
      if ($urandom_range(99) < 2) pop_hold = $urandom_range(5, 20);
      pop <= ($urandom_range(99) >= 10);
    end
  end

  function automatic item_t make_item(logic [1:0] act, logic [7:0] a, logic [7:0] b,
                                      logic v);
    item_t it;
    it.action      = act;
    it.first_node  = a;
    it.second_node = b;
    it.edge_value  = v;
    return it;
  endfunction

  // Leaves push high so back-to-back items need no gap.
  task automatic send(item_t it);
    if (!calm && $urandom_range(99) < 25) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_edge(logic [7:0] a, logic [7:0] b, logic v);
    send(make_item(ACT_EDGE, a, b, v));
  endtask

  task automatic send_member(logic [7:0] a);
    send(make_item(ACT_MEMBER, a, 8'($urandom), 1'($urandom)));
  endtask

  task automatic send_verdict();
    send(make_item(ACT_VERDICT, 8'($urandom), 8'($urandom), 1'($urandom)));
  endtask

  // Hold off until every verdict is back and the back end has gone quiet.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.node_count = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[8:0] !== value)
      sb.report($sformatf("node_count reads %0d, expected %0d", prdata[8:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_node(int span);
    return (span == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(span - 1));
  endfunction

  function automatic logic [7:0] pick_bad_node(int span);
    return 8'($urandom_range(span, 255));
  endfunction

  // One candidate set: mostly wired as a clique, sometimes with a cut edge.
  task automatic random_set(int span);
    logic [7:0] nodes [$];
    int         k;
    int         mode;
    int         i;
    int         j;
    k    = $urandom_range(0, 6);
    mode = $urandom_range(9);
    for (i = 0; i < k; i++) nodes.push_back(pick_node(span));
    if (mode < 8) begin
      for (i = 0; i < k; i++)
        for (j = i + 1; j < k; j++)
          send_edge(nodes[i], nodes[j], 1'b1);
      if (mode >= 6 && k > 1) begin
        i = $urandom_range(k - 1);
        j = $urandom_range(k - 1);
        send_edge(nodes[j], nodes[i], 1'b0);
      end
    end
    nodes.shuffle();
    foreach (nodes[n]) begin
      if ($urandom_range(99) < 10)
        send(make_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
      if (span < MAX_NODES && $urandom_range(99) < 5) send_member(pick_bad_node(span));
      send_member(nodes[n]);
      if ($urandom_range(99) < 10) send_member(nodes[$urandom_range(n)]);
    end
    send_verdict();
  endtask

  initial begin
    int settings [$];
    int phase;
    int span;
    int phase_end;
    logic [8:0] cfg;

    settings = '{2, 300, 64, 511, 3, 1, 256, 65, 200, 128, 0, 255};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);
    write_node_count(NODE_COUNT_RESET);

    // Extreme nodes, repeat member, empty and single sets.
    send_edge(8'd0, 8'd1, 1'b1);
    send_edge(8'd0, 8'd255, 1'b1);
    send_edge(8'd255, 8'd1, 1'b1);
    send_member(8'd0);
    send_member(8'd255);
    send_member(8'd1);
    send_member(8'd0);
    send_verdict();
    send_verdict();
    send_member(8'd128);
    send_verdict();
    // Self edge must not matter.
    send_edge(8'd7, 8'd7, 1'b1);
    send_member(8'd7);
    send_member(8'd7);
    send_verdict();
    // Disconnect a pair.
    send_edge(8'd1, 8'd255, 1'b0);
    send_member(8'd1);
    send_member(8'd255);
    send_verdict();
    send(make_item(ACT_UNUSED, 8'd255, 8'd255, 1'b1));
    drain();
    // Zero node count: every index is out of range.
    write_node_count(9'd0);
    send_edge(8'd0, 8'd0, 1'b1);
    send_member(8'd0);
    send_verdict();
    drain();
    write_node_count(9'd1);
    send_member(8'd0);
    send_edge(8'd0, 8'd1, 1'b1);
    send_verdict();
    drain();
    // Members accepted before a node count change stay in the set.
    write_node_count(NODE_COUNT_RESET);
    send_member(8'd0);
    send_member(8'd1);
    drain();
    write_node_count(9'd1);
    send_member(8'd1);
    send_member(8'd0);
    send_verdict();
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      cfg  = (phase < settings.size()) ? 9'(settings[phase]) : 9'($urandom_range(1, 256));
      span = (cfg > MAX_NODES) ? MAX_NODES : int'(cfg);
      write_node_count(cfg);
      calm = (phase == 6);
      phase_end = items_sent + (calm ? 250 : 100);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) random_set(span);
      drain();
      calm = 1'b0;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ccm_pkg.sv
sv/ccm_fifo.sv
sv/ccm_front.sv
sv/ccm_back.sv
sv/clique_membership_checker.sv
sim/tb_clique_membership_checker.sv
